### rtl/fkstore_pkg.sv
// ----------------------------------------------------------------------------
// fkstore_pkg
// Shared types and constants for the insertion-order key/value store.
// ----------------------------------------------------------------------------
package fkstore_pkg;

  // number of entries in the row of cells
  localparam int CAPACITY = 8;
  // stored key and value widths (the low bits of the item fields)
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  // width of the key, value and result fields on the channels
  localparam int FIELD_W  = 32;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CAPACITY-1:0] cell_vec_t;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_FIND   = 1'b1
  } cmd_t;

  // one entry as it moves from cell to cell
  typedef struct packed {
    logic valid;
    key_t key;
    val_t value;
  } entry_t;

endpackage

### rtl/fkstore_if.sv
// ----------------------------------------------------------------------------
// fkstore_req_if / fkstore_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fkstore_req_if;
  logic                 valid;
  logic                 ready;
  logic                 command;
  fkstore_pkg::field_t  key;
  fkstore_pkg::field_t  value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface fkstore_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 success;
  fkstore_pkg::field_t  found_value;
  logic                 evicted;
  fkstore_pkg::field_t  evicted_key;

  modport source (output valid, output success, output found_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input success, input found_value, input evicted,
                  input evicted_key, output ready);
endinterface

### rtl/fkstore_cell.sv
// ----------------------------------------------------------------------------
// fkstore_cell
// One entry of the row: holds key, value and valid, compares against the
// lookup key and takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module fkstore_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  fkstore_pkg::entry_t prev_i,
  input  fkstore_pkg::key_t   lookup_key,
  output fkstore_pkg::entry_t ent_o,
  output logic                match_o,
  output fkstore_pkg::val_t   match_val_o
);
  import fkstore_pkg::*;

  logic valid_r, valid_nxt;
  key_t key_r,   key_nxt;
  val_t value_r, value_nxt;

  // take the neighbor's entry on a shift
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (shift_en) begin
      valid_nxt = prev_i.valid;
      key_nxt   = prev_i.key;
      value_nxt = prev_i.value;
    end
  end

  // valid bit is control state, key and value are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  // compare and gated value for the match tree
  assign match_o     = valid_r && (key_r == lookup_key);
  assign match_val_o = match_o ? value_r : '0;
  assign ent_o       = '{valid: valid_r, key: key_r, value: value_r};

endmodule

### rtl/fifo_replacement_key_store.sv
// ----------------------------------------------------------------------------
// fifo_replacement_key_store
// Key/value store of CAPACITY entries with insertion-order replacement.
// Each result item is registered in the output register as its request item
// is accepted. Throughput: one item per cycle while out_ch.ready is high, set
// by the parallel compare in every cell and the single output register.
// Reset: synchronous, clears every valid bit and the output valid; stored
// keys and values are not reset and are only read behind a valid bit.
// ----------------------------------------------------------------------------
module fifo_replacement_key_store (
  input  logic                 clk,
  input  logic                 rst_n,
  fkstore_req_if.sink          in_ch,
  fkstore_rsp_if.source        out_ch
);
  import fkstore_pkg::*;

  entry_t    chain [CAPACITY+1];
  cell_vec_t match_vec;
  cell_vec_t valid_vec;
  val_t      match_vals [CAPACITY];

  logic   accept;
  logic   is_find;
  logic   hit;
  logic   shift_en;
  key_t   req_key;
  val_t   found_v;

  logic   out_valid_r, out_valid_nxt;
  logic   out_success_r;
  field_t out_found_r;
  logic   out_evicted_r;
  field_t out_evkey_r;

  // handshake: the output register parts the two sides
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_find     = (in_ch.command == CMD_FIND);
  assign req_key     = key_t'(in_ch.key);

  // new entry enters at the front of the row
  assign chain[0] = '{valid: 1'b1, key: req_key, value: val_t'(in_ch.value)};

  // row of cells, newest first
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    fkstore_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (shift_en),
      .prev_i      (chain[i]),
      .lookup_key  (req_key),
      .ent_o       (chain[i+1]),
      .match_o     (match_vec[i]),
      .match_val_o (match_vals[i])
    );
    assign valid_vec[i] = chain[i+1].valid;
  end

  // keys are unique, so an or over the gated values picks the match
  always_comb begin
    found_v = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_v = found_v | match_vals[i];
    end
  end

  assign hit      = |match_vec;
  assign shift_en = accept && !is_find && !hit;

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_success_r <= hit == is_find;
      out_found_r   <= (is_find && hit) ? field_t'(found_v) : '0;
      out_evicted_r <= shift_en && chain[CAPACITY].valid;
      out_evkey_r   <= (shift_en && chain[CAPACITY].valid) ?
                       field_t'(chain[CAPACITY].key) : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.success     = out_success_r;
  assign out_ch.found_value = out_found_r;
  assign out_ch.evicted     = out_evicted_r;
  assign out_ch.evicted_key = out_evkey_r;

  // at most one cell matches a key
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matches the key");

  // valid entries fill the row from the front
  a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & cell_vec_t'(valid_vec + 1'b1)) == '0)
    else $error("valid entries are not contiguous from the front");

  // an accepted insert leaves the front cell valid
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> valid_vec[0])
    else $error("insert did not fill the front cell");

  // every accepted item produces a waiting result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // eviction only happens on a successful insert
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evicted_r) |-> out_success_r)
    else $error("eviction reported without success");

endmodule

### bench/key_store_check_pkg.sv
// ----------------------------------------------------------------------------
// key_store_check_pkg
// Result prediction and result checking for the insertion-order key store.
// ----------------------------------------------------------------------------
package key_store_check_pkg;
  import fkstore_pkg::*;

  // one result item as seen on the result channel
  typedef struct packed {
    logic   success;
    field_t found_value;
    logic   evicted;
    field_t evicted_key;
  } lookup_result_t;

  class key_store_scoreboard;
    // predicted row of entries, newest at position 0
    key_t           row_key[CAPACITY];
    val_t           row_val[CAPACITY];
    bit             row_valid[CAPACITY];
    lookup_result_t pending_results[$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned inserts_taken;
    int unsigned duplicates;
    int unsigned evictions;
    int unsigned finds;
    int unsigned find_hits;

    function new();
      foreach (row_valid[i]) begin
        row_valid[i] = 1'b0;
        row_key[i]   = '0;
        row_val[i]   = '0;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // accepted request item: update the predicted row, queue its result
    function void note_request(cmd_t cmd, field_t key_in, field_t value_in);
      key_t           k;
      val_t           v;
      int             hit;
      lookup_result_t res;
      k   = key_t'(key_in);
      v   = val_t'(value_in);
      hit = -1;
      res = '0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit < 0 && row_valid[i] && row_key[i] == k) hit = i;
      end
      if (cmd == CMD_FIND) begin
        finds++;
        if (hit >= 0) begin
          res.success     = 1'b1;
          res.found_value = field_t'(row_val[hit]);
          find_hits++;
        end
      end else if (hit >= 0) begin
        // duplicate key: refused, row untouched
        duplicates++;
      end else begin
        inserts_taken++;
        if (row_valid[CAPACITY-1]) begin
          res.evicted     = 1'b1;
          res.evicted_key = field_t'(row_key[CAPACITY-1]);
          evictions++;
        end
        for (int i = CAPACITY - 1; i > 0; i--) begin
          row_key[i]   = row_key[i-1];
          row_val[i]   = row_val[i-1];
          row_valid[i] = row_valid[i-1];
        end
        row_key[0]   = k;
        row_val[0]   = v;
        row_valid[0] = 1'b1;
        res.success  = 1'b1;
      end
      pending_results.push_back(res);
    endfunction

    // accepted result item: compare with the oldest prediction
    function void check_result(lookup_result_t got);
      lookup_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result item with nothing pending: success=%b found=%h ev=%b evkey=%h",
                   $time, got.success, got.found_value, got.evicted, got.evicted_key);
        return;
      end
      want = pending_results.pop_front();
      if (got.success !== want.success || got.found_value !== want.found_value ||
          got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d mismatch: success %b/%b found %h/%h ev %b/%b evkey %h/%h",
                   $time, results_seen, want.success, got.success, want.found_value,
                   got.found_value, want.evicted, got.evicted, want.evicted_key,
                   got.evicted_key);
      end
    endfunction
  endclass

endpackage

### bench/tb_fifo_replacement_key_store.sv
// ----------------------------------------------------------------------------
// tb_fifo_replacement_key_store
// Drives insert and find requests into the key store with random gaps and
// random result back-pressure; every result is checked against a predicted
// row of entries (duplicate refusal, oldest-entry eviction, find hits/misses).
// ----------------------------------------------------------------------------
module tb_fifo_replacement_key_store;
  timeunit 1ns;
  timeprecision 1ps;

  import fkstore_pkg::*;
  import key_store_check_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int POOL_SIZE    = 16;

  logic clk = 1'b0;
  logic rst_n;

  fkstore_req_if req_ch ();
  fkstore_rsp_if rsp_ch ();

  fifo_replacement_key_store u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  key_store_scoreboard sb = new();

  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;
  field_t      key_pool[POOL_SIZE];

  // clock
  always #5 clk = ~clk;

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned idle_length(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one request item, after an optional idle gap with junk payload
  task automatic drive_request(cmd_t cmd, field_t key, field_t value);
    int unsigned gap;
    gap = idle_length(send_calm);
    if (gap > 0) begin
      req_ch.valid   <= 1'b0;
      req_ch.command <= 1'($urandom_range(0, 1));
      req_ch.key     <= $urandom;
      req_ch.value   <= $urandom;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key     <= key;
    req_ch.value   <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(cmd, key, value);
  endtask

  // hold the sender off until every pending result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // result side: check accepted items, stall at random
  initial begin
    int unsigned stall_left;
    lookup_result_t got;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_ch.valid !== 1'b0 && rsp_ch.ready === 1'b1) begin
        got = '{success: rsp_ch.success, found_value: rsp_ch.found_value,
                evicted: rsp_ch.evicted, evicted_key: rsp_ch.evicted_key};
        if (rsp_ch.valid !== 1'b1) got.success = 1'bx;
        sb.check_result(got);
      end
      if (rst_n !== 1'b1) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = idle_length(recv_calm);
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin
    cmd_t   cmd;
    field_t key;
    int unsigned r;

    rst_n          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_INSERT;
    req_ch.key     <= '0;
    req_ch.value   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extreme keys and values, duplicates
    drive_request(CMD_FIND,   32'h0000_0000, 32'hFFFF_FFFF);  // miss on empty store
    drive_request(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    drive_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_request(CMD_FIND,   32'h0000_0000, 32'h1234_5678);
    drive_request(CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
    drive_request(CMD_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);  // duplicate refused
    drive_request(CMD_FIND,   32'h0000_0000, 32'h0000_0000);  // still the old value
    // fill the row
    drive_request(CMD_INSERT, 32'h0000_0001, 32'h8000_0000);
    drive_request(CMD_INSERT, 32'h8000_0000, 32'h0000_0001);
    drive_request(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    drive_request(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    drive_request(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    drive_request(CMD_INSERT, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
    // full row: duplicate evicts nothing, new keys push the oldest out
    drive_request(CMD_INSERT, 32'hAAAA_AAAA, 32'h0000_0000);
    drive_request(CMD_INSERT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    drive_request(CMD_INSERT, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
    drive_request(CMD_FIND,   32'h0000_0000, 32'h0000_0000);  // evicted, now a miss
    drive_request(CMD_FIND,   32'h0000_0001, 32'hFFFF_FFFF);  // oldest surviving entry
    drive_request(CMD_FIND,   32'hF0F0_F0F0, 32'h0000_0000);  // newest entry

    // random: keys mostly from a small pool so hits, duplicates and evictions recur
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 99) < 5) key_pool[$urandom_range(0, POOL_SIZE-1)] = $urandom;
      r   = $urandom_range(0, 99);
      cmd = (r < 45) ? CMD_INSERT : CMD_FIND;
      if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, POOL_SIZE-1)];
      else                            key = $urandom;
      drive_request(cmd, key, $urandom);
    end

    // wait out the pending results and the output register
    drain_results();
    repeat (5) @(posedge clk);

    $display("covered %0d finds (%0d hits), %0d accepted inserts, %0d refused duplicates",
             sb.finds, sb.find_hits, sb.inserts_taken, sb.duplicates);
    $display("%0d evictions, %0d result items, %0d mismatches",
             sb.evictions, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/fkstore_pkg.sv
rtl/fkstore_if.sv
rtl/fkstore_cell.sv
rtl/fifo_replacement_key_store.sv
bench/key_store_check_pkg.sv
bench/tb_fifo_replacement_key_store.sv
